>>> rtl/mbg_pkg.sv
// Package for multiply_to_base1000_groups: sequencer states, cell operations,
// the cell control struct and the fixed field widths. No dependencies.
package mbg_pkg;

   localparam int GROUP_RADIX = 1000;
   localparam int LIMB_W      = 10;   // one base-1000 group, 0..999
   localparam int CARRY_W     = 2;    // pending carry per cell, 0..3
   localparam int SUM_W       = 12;   // cell sum before the split, below 4000
   localparam int INDEX_W     = 3;    // group_index field width

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_CFLUSH,
      ST_LOAD,
      ST_MULT,
      ST_MFLUSH,
      ST_FIND,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_CONV,
      OP_LOAD,
      OP_MULT,
      OP_FLUSH,
      OP_HOLD
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        add_bit;
   } cell_ctrl_type;

endpackage

>>> rtl/mbg_ifs.sv
// Channel interfaces for multiply_to_base1000_groups: operand word in,
// group word out. Depends on mbg_pkg for the fixed output widths.
interface mbg_req_if #(
   parameter int OPERAND_BITS = 31
);
   logic                    valid;
   logic                    ready;
   logic [OPERAND_BITS-1:0] multiplicand;
   logic [OPERAND_BITS-1:0] multiplier;

   modport source (output valid, output multiplicand, output multiplier, input ready);
   modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface mbg_rsp_if
   import mbg_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [LIMB_W-1:0]  group_value;
   logic [INDEX_W-1:0] group_index;
   logic               last_group;

   modport source (output valid, output group_value, output group_index, output last_group,
                   input ready);
   modport sink   (input valid, input group_value, input group_index, input last_group,
                   output ready);
endinterface

>>> rtl/mbg_cell.sv
// One radix-1000 limb cell: limb, pending carry and multiplicand group.
// Depends on mbg_pkg.
module mbg_cell
   import mbg_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic                first,      // tied high on cell 0 only
   input  logic [CARRY_W-1:0]  carry_in,   // registered carry of the lower cell
   output logic [CARRY_W-1:0]  carry_out,
   output logic [LIMB_W-1:0]   limb
);

   logic [LIMB_W-1:0]  limb_ff, limb_in;
   logic [LIMB_W-1:0]  mc_ff, mc_in;
   logic [CARRY_W-1:0] carry_ff, carry_in_nx;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   addend;
   logic [CARRY_W-1:0] quot;
   logic [SUM_W-1:0]   rem;

   // Late carries come in doubled: the whole row doubled since they left.
   always_comb begin
      addend = '0;
      case (ctrl.op)
         OP_CONV: addend = SUM_W'(ctrl.add_bit & first);
         OP_MULT: addend = ctrl.add_bit ? SUM_W'(mc_ff) : '0;
         default: addend = '0;
      endcase
      if (ctrl.op == OP_FLUSH) begin
         sum = SUM_W'(limb_ff) + SUM_W'(carry_in);
      end else begin
         sum = {1'b0, limb_ff, 1'b0} + SUM_W'({carry_in, 1'b0}) + addend;
      end
   end

   // Sum stays below 4000: three compares give the quotient.
   always_comb begin
      if (sum >= SUM_W'(3 * GROUP_RADIX)) begin
         quot = 2'd3;
      end else if (sum >= SUM_W'(2 * GROUP_RADIX)) begin
         quot = 2'd2;
      end else if (sum >= SUM_W'(GROUP_RADIX)) begin
         quot = 2'd1;
      end else begin
         quot = 2'd0;
      end
      rem = sum - SUM_W'(quot) * SUM_W'(GROUP_RADIX);
   end

   always_comb begin
      limb_in     = limb_ff;
      mc_in       = mc_ff;
      carry_in_nx = carry_ff;
      case (ctrl.op)
         OP_CLEAR: begin
            limb_in     = '0;
            carry_in_nx = '0;
         end
         OP_LOAD: begin
            mc_in       = limb_ff;
            limb_in     = '0;
            carry_in_nx = '0;
         end
         OP_CONV, OP_MULT, OP_FLUSH: begin
            limb_in     = rem[LIMB_W-1:0];
            carry_in_nx = quot;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      limb_ff  <= limb_in;
      mc_ff    <= mc_in;
      carry_ff <= carry_in_nx;
   end

   assign carry_out = carry_ff;
   assign limb      = limb_ff;

endmodule

>>> rtl/multiply_to_base1000_groups.sv
// Top level of multiply_to_base1000_groups: sequencer, operand registers,
// row of mbg_cell limbs and the output word register. Depends on mbg_pkg, mbg_ifs.
//
//   channel   dir  handshake    word contents
//   req_chan  in   valid/ready  multiplicand, multiplier
//   rsp_chan  out  valid/ready  group_value, group_index, last_group
//
// One item passes through the cell row in order (convert multiplicand, flush,
// load, multiply, flush, find top group); then the groups are emitted from the
// top group down, and the sequencer returns to idle to take the next word. The
// carry walk through the cell row, one cell per cycle, sets the flush lengths.
// Reset clears the sequencer and the output valid; cell contents are cleared on
// every accepted word. A stalled rsp_chan holds emission; the last group may still
// wait in the output register while the next word is accepted and worked on.
module multiply_to_base1000_groups
   import mbg_pkg::*;
#(
   parameter int OPERAND_BITS = 31,
   parameter int GROUP_COUNT  = 7
) (
   input  logic          clock,
   input  logic          reset,
   mbg_req_if.sink       req_chan,
   mbg_rsp_if.source     rsp_chan
);

   localparam int BIT_W = $clog2(OPERAND_BITS);
   localparam int CNT_W = $clog2(OPERAND_BITS > GROUP_COUNT ? OPERAND_BITS : GROUP_COUNT);
   localparam int IDX_W = $clog2(GROUP_COUNT);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [OPERAND_BITS-1:0] mcand_ff, mcand_in;
   logic [OPERAND_BITS-1:0] mplier_ff, mplier_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LIMB_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic                   rsp_last_ff, rsp_last_in;

   cell_ctrl_type          ctrl;
   logic                   req_accept;
   logic                   out_free;
   logic                   cnt_zero;
   logic [IDX_W-1:0]       top_idx;

   logic [LIMB_W-1:0]      limbs [GROUP_COUNT];
   logic [CARRY_W-1:0]     carries [GROUP_COUNT];

   assign req_accept = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign cnt_zero   = (cnt_ff == '0);

   // Row of limb cells, group 0 at the bottom; carry out of the top is dropped.
   assign carries[0] = '0;
   for (genvar k = 0; k < GROUP_COUNT; k++) begin : g_cell
      if (k < GROUP_COUNT - 1) begin : g_mid
         mbg_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .first     (k == 0),
            .carry_in  (carries[k]),
            .carry_out (carries[k+1]),
            .limb      (limbs[k])
         );
      end else begin : g_top
         mbg_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .first     (k == 0),
            .carry_in  (carries[k]),
            .carry_out (),
            .limb      (limbs[k])
         );
      end
   end

   // Highest non-zero group; group 0 when all are zero.
   always_comb begin
      top_idx = '0;
      for (int k = 1; k < GROUP_COUNT; k++) begin
         if (limbs[k] != '0) begin
            top_idx = IDX_W'(k);
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_CONV;
         ST_CONV:   if (cnt_zero) state_in = ST_CFLUSH;
         ST_CFLUSH: if (cnt_zero) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_MULT;
         ST_MULT:   if (cnt_zero) state_in = ST_MFLUSH;
         ST_MFLUSH: if (cnt_zero) state_in = ST_FIND;
         ST_FIND:   state_in = ST_EMIT;
         ST_EMIT:   if (out_free && idx_ff == '0) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: cell control and input ready
   always_comb begin
      ctrl.op      = OP_HOLD;
      ctrl.add_bit = 1'b0;
      req_chan.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.op        = OP_CLEAR;
            req_chan.ready = 1'b1;
         end
         ST_CONV: begin
            ctrl.op      = OP_CONV;
            ctrl.add_bit = mcand_ff[cnt_ff[BIT_W-1:0]];
         end
         ST_CFLUSH, ST_MFLUSH: ctrl.op = OP_FLUSH;
         ST_LOAD:   ctrl.op = OP_LOAD;
         ST_MULT: begin
            ctrl.op      = OP_MULT;
            ctrl.add_bit = mplier_ff[cnt_ff[BIT_W-1:0]];
         end
         ST_FIND, ST_EMIT: ctrl.op = OP_HOLD;
         default:   ctrl.op = OP_HOLD;
      endcase
   end

   // Counters, operands and output word register
   always_comb begin
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_accept) begin
         mcand_in  = req_chan.multiplicand;
         mplier_in = req_chan.multiplier;
         cnt_in    = CNT_W'(OPERAND_BITS - 1);
      end

      case (state_ff)
         ST_CONV, ST_MULT: begin
            cnt_in = cnt_zero ? CNT_W'(GROUP_COUNT - 1) : cnt_ff - 1'b1;
         end
         ST_CFLUSH, ST_MFLUSH: begin
            cnt_in = cnt_ff - 1'b1;
         end
         ST_LOAD: cnt_in = CNT_W'(OPERAND_BITS - 1);
         ST_FIND: idx_in = top_idx;
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = limbs[idx_ff];
               rsp_index_in = idx_ff;
               rsp_last_in  = (idx_ff == '0);
               idx_in       = idx_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.group_value = rsp_value_ff;
   assign rsp_chan.group_index = INDEX_W'(rsp_index_ff);
   assign rsp_chan.last_group  = rsp_last_ff;

endmodule
